FILE: rtl/mspc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes, result word layout and constants of the motor speed PI controller.
package mspc_pkg;

	localparam int PULSE_COUNT_BITS_DEF = 16;

	localparam int DUTY_W     = 20;
	localparam int SPEED_W    = 23;
	localparam int TSTEP_W    = 16;
	localparam int RPM_W      = 10;
	localparam int GAIN_W     = 8;
	localparam int ESUM_W     = 21;
	localparam int ADJ_W      = 26;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [DUTY_W-1:0]  DUTY_MAX  = 20'd1000000;
	localparam logic [SPEED_W-1:0] SPEED_MAX = 23'h7FFFFF;

	localparam logic [30:0] DIV100_MAGIC = 31'h51EB851F;
	localparam int          DIV100_SHIFT = 37;

	localparam logic [1:0] EVT_EDGE = 2'd0;
	localparam logic [1:0] EVT_TICK = 2'd1;
	localparam logic [1:0] EVT_BYTE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_START_DUTY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_STEP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RPM_PULSE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN    = 3'd6;

	localparam logic [7:0] CH_START  = 8'h73;
	localparam logic [7:0] CH_STOP   = 8'h78;
	localparam logic [7:0] CH_DIR_C  = 8'h63;
	localparam logic [7:0] CH_DIR_V  = 8'h76;
	localparam logic [7:0] CH_FASTER = 8'h66;
	localparam logic [7:0] CH_SLOWER = 8'h64;
	localparam logic [7:0] CH_AUTO   = 8'h61;
	localparam logic [7:0] CH_MANUAL = 8'h6D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;

	typedef struct packed {
		logic               master_enable;
		logic               dir_a;
		logic               dir_b;
		logic [DUTY_W-1:0]  duty;
		logic [SPEED_W-1:0] measured_rpm;
		logic [SPEED_W-1:0] target_speed;
		logic               auto_active;
	} result_t;

	typedef struct packed {
		logic                     busy;
		logic                     valid;
		logic                     pi_en;
		logic [SPEED_W-1:0]       speed;
		logic signed [ESUM_W-1:0] esum;
		logic signed [ADJ_W-1:0]  adj;
	} tick_res_t;

endpackage

FILE: rtl/mspc_in_if.sv
`timescale 1ns / 1ps
// Event channel: sensor edge, period tick or command byte.
interface mspc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] command_byte;

	modport source (output valid, output cmd, output command_byte, input ready);
	modport sink (input valid, input cmd, input command_byte, output ready);
endinterface

FILE: rtl/mspc_out_if.sv
`timescale 1ns / 1ps
// Status channel: driver lines, duty, speed, target and mode after each event.
interface mspc_out_if;
	logic                        valid;
	logic                        ready;
	logic                        master_enable;
	logic                        dir_a;
	logic                        dir_b;
	logic [mspc_pkg::DUTY_W-1:0]  duty;
	logic [mspc_pkg::SPEED_W-1:0] measured_rpm;
	logic [mspc_pkg::SPEED_W-1:0] target_speed;
	logic                        auto_active;

	modport source (output valid, output master_enable, output dir_a, output dir_b,
		output duty, output measured_rpm, output target_speed, output auto_active,
		input ready);
	modport sink (input valid, input master_enable, input dir_a, input dir_b,
		input duty, input measured_rpm, input target_speed, input auto_active,
		output ready);
endinterface

FILE: rtl/mspc_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
interface mspc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mspc_pkg::CFG_IDX_W-1:0]  index;
	logic [mspc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/motor_speed_pi_controller_core.sv
`timescale 1ns / 1ps
// Top level of the motor speed PI controller.
//
// evt carries one event word: cmd 0 is a sensor rising edge, 1 a control period
// tick, 2 a command byte in command_byte; cmd 3 changes no state. Every accepted event
// gives one word on sts with the driver lines, applied duty, measured speed,
// target and mode after the update. cfg writes the seven registers by index;
// an index beyond the list is dropped. Write cfg only while no event is in flight.
//
// Edges and command bytes may follow back to back; their word enters the result
// buffer on acceptance and shows on sts once the words ahead of it are taken. A
// tick's word passes the registers behind the speed multiplier, the PI gain
// multipliers and the divide-by-100 multiplier before it enters the buffer;
// evt.ready is low meanwhile.
//
// Results pass through a two-word buffer, so events are still accepted while a
// word waits on a stalled sts; with both words waiting evt.ready drops.
// Reset restores the register defaults, clears all motor state and empties the
// buffer; evt.ready is high as soon as reset is released.
module motor_speed_pi_controller_core #(
	parameter int PULSE_COUNT_BITS = mspc_pkg::PULSE_COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mspc_in_if.sink   evt,
	mspc_out_if.source sts,
	mspc_cfg_if.sink  cfg
);
	import mspc_pkg::*;

	localparam int PROD_W = PULSE_COUNT_BITS + RPM_W;
	localparam int SP_W   = (PROD_W > SPEED_W) ? PROD_W : SPEED_W + 1;

	logic [DUTY_W-1:0]  start_duty_q, duty_step_q, int_limit_q;
	logic [TSTEP_W-1:0] target_step_q;
	logic [RPM_W-1:0]   rpm_q;
	logic [GAIN_W-1:0]  kp_q, ki_q;

	logic [PULSE_COUNT_BITS-1:0] pulse_q, pulse_d;
	logic [SPEED_W-1:0]          speed_q, speed_d;
	logic [SPEED_W-1:0]          target_q, target_d;
	logic [DUTY_W-1:0]           manual_q, manual_d;
	logic [DUTY_W-1:0]           applied_q, applied_d;
	logic signed [ESUM_W-1:0]    esum_q, esum_d;
	logic                        auto_q, auto_d;
	logic                        en_q, en_d;
	logic                        dira_q, dira_d;
	logic                        dirb_q, dirb_d;

	logic               v_s1, pi_en_s1;
	logic [SPEED_W-1:0] speed_s1;

	tick_res_t tick;
	logic      accept, accept_tick, push, buf_full;
	result_t   push_word;

	logic [SP_W-1:0]         prod;
	logic [SPEED_W-1:0]      speed_sat;
	logic signed [27:0]      lvl_step;
	logic [SPEED_W:0]        tgt_sum;
	logic [SPEED_W-1:0]      tstep_ext;
	logic [DUTY_W-1:0]       start_clamped;

	function automatic logic [DUTY_W-1:0] sat_level(input logic signed [27:0] v);
		if (v > $signed({8'b0, DUTY_MAX})) begin
			return DUTY_MAX;
		end else if (v < 0) begin
			return '0;
		end else begin
			return DUTY_W'(v);
		end
	endfunction

	assign cfg.ready   = 1'b1;
	assign evt.ready   = !v_s1 && !tick.busy && !buf_full;
	assign accept      = evt.valid && evt.ready;
	assign accept_tick = accept && (evt.cmd == EVT_TICK);
	assign push        = (accept && (evt.cmd != EVT_TICK)) || tick.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_duty_q  <= 20'd300000;
			duty_step_q   <= 20'd50000;
			target_step_q <= 16'd100;
			rpm_q         <= 10'd80;
			int_limit_q   <= 20'd500000;
			kp_q          <= 8'd5;
			ki_q          <= 8'd1;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_START_DUTY:  start_duty_q  <= cfg.data;
				CFG_DUTY_STEP:   duty_step_q   <= cfg.data;
				CFG_TARGET_STEP: target_step_q <= cfg.data[TSTEP_W-1:0];
				CFG_RPM_PULSE:   rpm_q         <= cfg.data[RPM_W-1:0];
				CFG_INT_LIMIT:   int_limit_q   <= cfg.data;
				CFG_PROP_GAIN:   kp_q          <= cfg.data[GAIN_W-1:0];
				CFG_INT_GAIN:    ki_q          <= cfg.data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prod      = SP_W'(pulse_q) * SP_W'(rpm_q);
		speed_sat = (prod > SP_W'(SPEED_MAX)) ? SPEED_MAX : SPEED_W'(prod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept_tick;
		end
	end

	always_ff @(posedge clk) begin
		speed_s1 <= speed_sat;
		pi_en_s1 <= auto_q && (target_q != '0);
	end

	mspc_pi_pipe u_pi (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (v_s1),
		.pi_en  (pi_en_s1),
		.speed  (speed_s1),
		.target (target_q),
		.esum   (esum_q),
		.limit  (int_limit_q),
		.kp     (kp_q),
		.ki     (ki_q),
		.res    (tick)
	);

	always_comb begin
		pulse_d   = pulse_q;
		speed_d   = speed_q;
		target_d  = target_q;
		manual_d  = manual_q;
		applied_d = applied_q;
		esum_d    = esum_q;
		auto_d    = auto_q;
		en_d      = en_q;
		dira_d    = dira_q;
		dirb_d    = dirb_q;

		start_clamped = (start_duty_q > DUTY_MAX) ? DUTY_MAX : start_duty_q;
		tstep_ext     = SPEED_W'(target_step_q);
		tgt_sum       = {1'b0, target_q} + {1'b0, tstep_ext};
		lvl_step      = (evt.command_byte == CH_FASTER)
			? $signed({8'b0, manual_q}) + $signed({8'b0, duty_step_q})
			: $signed({8'b0, manual_q}) - $signed({8'b0, duty_step_q});

		if (tick.valid) begin
			speed_d = tick.speed;
			if (tick.pi_en) begin
				esum_d    = tick.esum;
				applied_d = sat_level($signed({8'b0, applied_q})
					+ $signed({{(28-ADJ_W){tick.adj[ADJ_W-1]}}, tick.adj}));
			end
		end else if (accept) begin
			case (evt.cmd)
				EVT_EDGE: begin
					if (pulse_q != {PULSE_COUNT_BITS{1'b1}}) pulse_d = pulse_q + 1'b1;
				end
				EVT_TICK: begin
					pulse_d = '0;
				end
				EVT_BYTE: begin
					case (evt.command_byte)
						CH_START: begin
							en_d      = 1'b1;
							auto_d    = 1'b0;
							manual_d  = start_clamped;
							applied_d = start_clamped;
						end
						CH_STOP: begin
							pulse_d   = '0;
							speed_d   = '0;
							target_d  = '0;
							manual_d  = '0;
							applied_d = '0;
							esum_d    = '0;
							auto_d    = 1'b0;
							en_d      = 1'b0;
							dira_d    = 1'b0;
							dirb_d    = 1'b0;
						end
						CH_DIR_C: begin
							dira_d = 1'b0;
							dirb_d = 1'b1;
						end
						CH_DIR_V: begin
							dira_d = 1'b1;
							dirb_d = 1'b0;
						end
						CH_FASTER, CH_SLOWER: begin
							if (!auto_q) begin
								manual_d  = sat_level(lvl_step);
								applied_d = sat_level(lvl_step);
							end
						end
						CH_AUTO: begin
							auto_d   = 1'b1;
							target_d = speed_q;
							esum_d   = '0;
						end
						CH_MANUAL: begin
							auto_d   = 1'b0;
							manual_d = applied_q;
						end
						CH_PLUS: begin
							if (auto_q) begin
								target_d = tgt_sum[SPEED_W] ? SPEED_MAX : tgt_sum[SPEED_W-1:0];
							end
						end
						CH_MINUS: begin
							if (auto_q) begin
								target_d = (target_q > tstep_ext) ? target_q - tstep_ext : '0;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q   <= '0;
			speed_q   <= '0;
			target_q  <= '0;
			manual_q  <= '0;
			applied_q <= '0;
			esum_q    <= '0;
			auto_q    <= 1'b0;
			en_q      <= 1'b0;
			dira_q    <= 1'b0;
			dirb_q    <= 1'b0;
		end else begin
			pulse_q   <= pulse_d;
			speed_q   <= speed_d;
			target_q  <= target_d;
			manual_q  <= manual_d;
			applied_q <= applied_d;
			esum_q    <= esum_d;
			auto_q    <= auto_d;
			en_q      <= en_d;
			dira_q    <= dira_d;
			dirb_q    <= dirb_d;
		end
	end

	always_comb begin
		push_word.master_enable = en_d;
		push_word.dir_a         = dira_d;
		push_word.dir_b         = dirb_d;
		push_word.duty          = applied_d;
		push_word.measured_rpm  = speed_d;
		push_word.target_speed  = target_d;
		push_word.auto_active   = auto_d;
	end

	mspc_result_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (buf_full),
		.sts       (sts)
	);

endmodule

FILE: rtl/mspc_pi_pipe.sv
`timescale 1ns / 1ps
// PI step pipeline: error, clamped integral, gain products and division by 100.
module mspc_pi_pipe (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               pi_en,
	input  logic [mspc_pkg::SPEED_W-1:0]       speed,
	input  logic [mspc_pkg::SPEED_W-1:0]       target,
	input  logic signed [mspc_pkg::ESUM_W-1:0] esum,
	input  logic [mspc_pkg::DUTY_W-1:0]        limit,
	input  logic [mspc_pkg::GAIN_W-1:0]        kp,
	input  logic [mspc_pkg::GAIN_W-1:0]        ki,
	output mspc_pkg::tick_res_t                res
);
	import mspc_pkg::*;

	logic                     v_s2, v_s3;
	logic                     pi_en_s2, pi_en_s3;
	logic [SPEED_W-1:0]       speed_s2, speed_s3;
	logic signed [ESUM_W-1:0] esum_s2, esum_s3;
	logic signed [32:0]       p_s2;
	logic signed [29:0]       i_s2;
	logic signed [ADJ_W-1:0]  adj_s3;

	logic signed [SPEED_W:0]   err;
	logic signed [SPEED_W+1:0] sum_raw;
	logic signed [SPEED_W+1:0] lim_s;
	logic signed [ESUM_W-1:0]  sum_clamped;
	logic signed [33:0]        num;
	logic [31:0]               mag;
	logic [62:0]               recip;
	logic [ADJ_W-1:0]          quot;

	always_comb begin
		err     = $signed({1'b0, target}) - $signed({1'b0, speed});
		sum_raw = $signed({{(SPEED_W+2-ESUM_W){esum[ESUM_W-1]}}, esum})
			+ $signed({err[SPEED_W], err});
		lim_s   = $signed({{(SPEED_W+2-DUTY_W){1'b0}}, limit});
		if (sum_raw > lim_s) begin
			sum_clamped = ESUM_W'(lim_s);
		end else if (sum_raw < -lim_s) begin
			sum_clamped = ESUM_W'(-lim_s);
		end else begin
			sum_clamped = ESUM_W'(sum_raw);
		end
	end

	always_comb begin
		num   = $signed({p_s2[32], p_s2}) + $signed({{4{i_s2[29]}}, i_s2});
		mag   = num[33] ? 32'(-num) : 32'(num);
		recip = {31'b0, mag} * {32'b0, DIV100_MAGIC};
		quot  = ADJ_W'(recip >> DIV100_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= start;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		pi_en_s2 <= pi_en;
		speed_s2 <= speed;
		esum_s2  <= sum_clamped;
		p_s2     <= $signed({1'b0, kp}) * err;
		i_s2     <= $signed({1'b0, ki}) * sum_clamped;
		pi_en_s3 <= pi_en_s2;
		speed_s3 <= speed_s2;
		esum_s3  <= esum_s2;
		adj_s3   <= num[33] ? -$signed(quot) : $signed(quot);
	end

	always_comb begin
		res.busy  = v_s2 | v_s3;
		res.valid = v_s3;
		res.pi_en = pi_en_s3;
		res.speed = speed_s3;
		res.esum  = esum_s3;
		res.adj   = adj_s3;
	end

endmodule

FILE: rtl/mspc_result_buf.sv
`timescale 1ns / 1ps
// Two-word result buffer in front of the status channel.
module mspc_result_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mspc_pkg::result_t push_word,
	output logic              full,
	mspc_out_if.source        sts
);
	import mspc_pkg::*;

	result_t    ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;
	result_t    head;

	assign pop  = sts.valid && sts.ready;
	assign full = cnt_q[1];
	assign head = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_word;
	end

	always_comb begin
		sts.valid         = cnt_q != 2'd0;
		sts.master_enable = head.master_enable;
		sts.dir_a         = head.dir_a;
		sts.dir_b         = head.dir_b;
		sts.duty          = head.duty;
		sts.measured_rpm  = head.measured_rpm;
		sts.target_speed  = head.target_speed;
		sts.auto_active   = head.auto_active;
	end

endmodule

FILE: tb/motor_speed_pi_controller_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the motor speed PI controller against a local predictor.
module motor_speed_pi_controller_core_test;
	import mspc_pkg::*;

	localparam logic [1:0] EVT_NONE = 2'd3;
	localparam int IDLE_MAX = 18;
	localparam int RESET_CYCLES = 7;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD = 300;
	localparam int REG_SLOTS = 8;
	localparam int GAIN_SCALE = 100;
	localparam int RANDOM_PER_PHASE = 215;
	localparam int RANDOM_PHASES = 6;
	localparam int EDGE_BURST = 40;
	localparam int REPORT_LIMIT = 40;
	localparam longint LIMIT_CYCLES = 1000000;

	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  code;
		int unsigned idle;
		bit          wait_empty;
	} event_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mspc_in_if  evt_ch ();
	mspc_out_if sts_ch ();
	mspc_cfg_if cfg_ch ();

	motor_speed_pi_controller_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.evt   (evt_ch),
		.sts   (sts_ch),
		.cfg   (cfg_ch)
	);

	always #5 clk = ~clk;

	logic [DUTY_W-1:0]  reg_start_duty = 20'd300000;
	logic [DUTY_W-1:0]  reg_duty_step = 20'd50000;
	logic [TSTEP_W-1:0] reg_target_step = 16'd100;
	logic [RPM_W-1:0]   reg_rpm_per_pulse = 10'd80;
	logic [DUTY_W-1:0]  reg_int_limit = 20'd500000;
	logic [GAIN_W-1:0]  reg_prop_gain = 8'd5;
	logic [GAIN_W-1:0]  reg_int_gain = 8'd1;

	logic [PULSE_COUNT_BITS_DEF-1:0] pulse_tally = '0;
	logic [SPEED_W-1:0]              speed_now = '0;
	logic [SPEED_W-1:0]              target_now = '0;
	logic [DUTY_W-1:0]               hand_level = '0;
	logic [DUTY_W-1:0]               applied_duty = '0;
	logic signed [ESUM_W-1:0]        err_total = '0;
	logic                            auto_on = 1'b0;
	logic                            drive_on = 1'b0;
	logic                            line_a = 1'b0;
	logic                            line_b = 1'b0;

	event_word_t event_queue[$];
	result_t     status_due[$];
	event_word_t next_word;
	result_t     want_word;

	int unsigned idle_max = 0;
	int unsigned stall_max = 0;
	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned stall_draw;
	int unsigned hold_left;
	int unsigned holds_asked = 0;
	int unsigned holds_served;
	int mismatches = 0;
	int events_applied = 0;
	int words_checked = 0;
	int reg_writes = 0;
	int settings_used = 0;
	longint cycle_count = 0;

	function automatic logic [DUTY_W-1:0] clip_duty(input longint v);
		if (v > longint'(DUTY_MAX))
			return DUTY_MAX;
		if (v < 0)
			return '0;
		return v[DUTY_W-1:0];
	endfunction

	function automatic result_t next_status(input logic [1:0] kind, input logic [7:0] code);
		longint rpm_full;
		longint err;
		longint acc;
		longint adj;
		longint lvl;
		result_t r;
		case (kind)
			EVT_EDGE: if (pulse_tally != '1) pulse_tally = pulse_tally + 1'b1;
			EVT_TICK: begin
				rpm_full = longint'(pulse_tally) * longint'(reg_rpm_per_pulse);
				speed_now = (rpm_full > longint'(SPEED_MAX)) ? SPEED_MAX : rpm_full[SPEED_W-1:0];
				pulse_tally = '0;
				if (auto_on && target_now != '0) begin
					err = longint'(target_now) - longint'(speed_now);
					acc = longint'(err_total) + err;
					if (acc > longint'(reg_int_limit))
						acc = longint'(reg_int_limit);
					if (acc < -longint'(reg_int_limit))
						acc = -longint'(reg_int_limit);
					err_total = acc[ESUM_W-1:0];
					adj = (longint'(reg_prop_gain) * err + longint'(reg_int_gain) * acc) / GAIN_SCALE;
					applied_duty = clip_duty(longint'(applied_duty) + adj);
				end
			end
			EVT_BYTE: case (code)
				CH_START: begin
					drive_on = 1'b1;
					auto_on = 1'b0;
					hand_level = clip_duty(longint'(reg_start_duty));
					applied_duty = hand_level;
				end
				CH_STOP: begin
					pulse_tally = '0;
					speed_now = '0;
					auto_on = 1'b0;
					target_now = '0;
					hand_level = '0;
					applied_duty = '0;
					err_total = '0;
					drive_on = 1'b0;
					line_a = 1'b0;
					line_b = 1'b0;
				end
				CH_DIR_C: begin
					line_a = 1'b0;
					line_b = 1'b1;
				end
				CH_DIR_V: begin
					line_a = 1'b1;
					line_b = 1'b0;
				end
				CH_FASTER, CH_SLOWER: if (!auto_on) begin
					lvl = (code == CH_FASTER) ? longint'(hand_level) + longint'(reg_duty_step)
						: longint'(hand_level) - longint'(reg_duty_step);
					hand_level = clip_duty(lvl);
					applied_duty = hand_level;
				end
				CH_AUTO: begin
					auto_on = 1'b1;
					target_now = speed_now;
					err_total = '0;
				end
				CH_MANUAL: begin
					auto_on = 1'b0;
					hand_level = applied_duty;
				end
				CH_PLUS: if (auto_on) begin
					lvl = longint'(target_now) + longint'(reg_target_step);
					target_now = (lvl > longint'(SPEED_MAX)) ? SPEED_MAX : lvl[SPEED_W-1:0];
				end
				CH_MINUS: if (auto_on)
					target_now = (target_now > reg_target_step) ? target_now - reg_target_step : '0;
				default: ;
			endcase
			default: ;
		endcase
		r.master_enable = drive_on;
		r.dir_a = line_a;
		r.dir_b = line_b;
		r.duty = applied_duty;
		r.measured_rpm = speed_now;
		r.target_speed = target_now;
		r.auto_active = auto_on;
		return r;
	endfunction

	task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] seen);
		if (seen !== want) begin
			if (mismatches < REPORT_LIMIT)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
			mismatches++;
		end
	endtask

	task automatic add_event(input logic [1:0] kind, input logic [7:0] code,
			input bit wait_empty = 1'b0);
		event_word_t w;
		w.kind = kind;
		w.code = code;
		w.idle = $urandom_range(0, idle_max);
		w.wait_empty = wait_empty;
		event_queue.push_back(w);
	endtask

	task automatic add_random(input int n);
		logic [7:0] ops [12];
		int made;
		ops = '{CH_START, CH_AUTO, CH_AUTO, CH_AUTO, CH_MANUAL, CH_FASTER, CH_SLOWER,
			CH_PLUS, CH_MINUS, CH_DIR_C, CH_DIR_V, CH_STOP};
		made = 0;
		while (made < n) begin
			repeat ($urandom_range(0, 24)) begin
				add_event(EVT_EDGE, 8'($urandom));
				made++;
			end
			if ($urandom_range(0, 2) == 0) begin
				add_event(EVT_BYTE, ops[$urandom_range(0, 11)]);
				made++;
			end
			if ($urandom_range(0, 19) == 0)
				add_event($urandom_range(0, 1) ? EVT_NONE : EVT_BYTE, 8'($urandom));
			add_event(EVT_TICK, 8'($urandom), $urandom_range(0, 29) == 0);
			made++;
		end
	endtask

	task automatic settle();
		while (event_queue.size() != 0 || evt_ch.valid || status_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input logic [19:0] sd, input logic [19:0] ds, input logic [19:0] ts,
			input logic [19:0] rp, input logic [19:0] il, input logic [19:0] kp,
			input logic [19:0] ki);
		logic [CFG_DATA_W-1:0] vals [REG_SLOTS];
		logic [CFG_IDX_W-1:0] idx;
		vals = '{sd, ds, ts, rp, il, kp, ki, 20'($urandom)};
		for (int i = 0; i < REG_SLOTS; i++) begin
			idx = CFG_IDX_W'(i);
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx;
			cfg_ch.data <= vals[i];
			do @(posedge clk); while (!cfg_ch.ready);
			case (idx)
				CFG_START_DUTY:  reg_start_duty = vals[i];
				CFG_DUTY_STEP:   reg_duty_step = vals[i];
				CFG_TARGET_STEP: reg_target_step = vals[i][TSTEP_W-1:0];
				CFG_RPM_PULSE:   reg_rpm_per_pulse = vals[i][RPM_W-1:0];
				CFG_INT_LIMIT:   reg_int_limit = vals[i];
				CFG_PROP_GAIN:   reg_prop_gain = vals[i][GAIN_W-1:0];
				CFG_INT_GAIN:    reg_int_gain = vals[i][GAIN_W-1:0];
				default: ;
			endcase
			reg_writes++;
		end
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_ch.valid <= 1'b0;
			evt_ch.cmd <= EVT_EDGE;
			evt_ch.command_byte <= 8'h00;
			gap_left <= 0;
		end else if (evt_ch.valid && !evt_ch.ready) begin
			// hold the word until taken
		end else if (gap_left != 0) begin
			evt_ch.valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (event_queue.size() != 0 && !(event_queue[0].wait_empty &&
				(evt_ch.valid || status_due.size() != 0))) begin
			next_word = event_queue.pop_front();
			evt_ch.valid <= 1'b1;
			evt_ch.cmd <= next_word.kind;
			evt_ch.command_byte <= next_word.code;
			gap_left <= next_word.idle;
		end else begin
			evt_ch.valid <= 1'b0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sts_ch.ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			holds_served <= 0;
		end else begin
			if (evt_ch.valid && evt_ch.ready) begin
				status_due.push_back(next_status(evt_ch.cmd, evt_ch.command_byte));
				events_applied++;
			end
			if (sts_ch.valid && sts_ch.ready) begin
				if (status_due.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t ns: status word with nothing expected, actual duty %0d",
							$time, sts_ch.duty);
					mismatches++;
				end else begin
					want_word = status_due.pop_front();
					flag_field("master_enable", 32'(want_word.master_enable),
						32'(sts_ch.master_enable));
					flag_field("dir_a", 32'(want_word.dir_a), 32'(sts_ch.dir_a));
					flag_field("dir_b", 32'(want_word.dir_b), 32'(sts_ch.dir_b));
					flag_field("duty", 32'(want_word.duty), 32'(sts_ch.duty));
					flag_field("measured_rpm", 32'(want_word.measured_rpm),
						32'(sts_ch.measured_rpm));
					flag_field("target_speed", 32'(want_word.target_speed),
						32'(sts_ch.target_speed));
					flag_field("auto_active", 32'(want_word.auto_active),
						32'(sts_ch.auto_active));
					words_checked++;
				end
			end
			if (holds_asked != holds_served) begin
				holds_served <= holds_asked;
				hold_left <= LONG_HOLD;
				sts_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				sts_ch.ready <= 1'b0;
			end else if (sts_ch.valid && sts_ch.ready) begin
				stall_draw = $urandom_range(0, stall_max);
				stall_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
				sts_ch.ready <= (stall_draw == 0);
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				sts_ch.ready <= 1'b0;
			end else begin
				sts_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("run timed out after %0d cycles, %0d words still expected",
				cycle_count, status_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_START_DUTY;
		cfg_ch.data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_max = IDLE_MAX;
		stall_max = IDLE_MAX;
		add_event(EVT_NONE, 8'hFF);
		add_event(EVT_BYTE, 8'h00);
		add_event(EVT_BYTE, 8'hFF);
		add_event(EVT_BYTE, CH_MINUS);
		add_event(EVT_BYTE, CH_START);
		add_event(EVT_BYTE, CH_FASTER);
		add_event(EVT_BYTE, CH_SLOWER);
		add_event(EVT_BYTE, CH_DIR_C);
		add_event(EVT_BYTE, CH_DIR_V);
		repeat (5) add_event(EVT_EDGE, 8'($urandom));
		add_event(EVT_TICK, 8'h00);
		add_event(EVT_BYTE, CH_AUTO);
		add_event(EVT_BYTE, CH_PLUS);
		add_event(EVT_EDGE, 8'hFF);
		add_event(EVT_TICK, 8'hFF);
		add_event(EVT_BYTE, CH_FASTER);
		add_event(EVT_BYTE, CH_MINUS);
		add_event(EVT_BYTE, CH_MANUAL);
		add_event(EVT_BYTE, CH_SLOWER);
		add_event(EVT_BYTE, CH_STOP);
		add_event(EVT_TICK, 8'h00);
		settle();

		set_regs(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		idle_max = 0;
		stall_max = 0;
		add_event(EVT_BYTE, CH_START);
		add_event(EVT_BYTE, CH_FASTER);
		add_event(EVT_BYTE, CH_SLOWER);
		add_event(EVT_BYTE, CH_FASTER);
		repeat (EDGE_BURST) add_event(EVT_EDGE, 8'($urandom));
		add_event(EVT_TICK, 8'h00);
		add_event(EVT_BYTE, CH_AUTO);
		add_event(EVT_BYTE, CH_PLUS);
		add_event(EVT_TICK, 8'h00);
		add_event(EVT_BYTE, CH_MINUS);
		add_event(EVT_TICK, 8'h00);
		add_event(EVT_BYTE, CH_STOP);
		settle();

		set_regs(20'd0, 20'd0, 20'd0, 20'd1, 20'd0, 20'd0, 20'd0);
		repeat (EDGE_BURST) add_event(EVT_EDGE, 8'($urandom));
		add_event(EVT_TICK, 8'h00);
		add_event(EVT_BYTE, CH_START);
		add_event(EVT_BYTE, CH_FASTER);
		add_event(EVT_BYTE, CH_AUTO);
		add_event(EVT_BYTE, CH_PLUS);
		add_event(EVT_TICK, 8'h00);
		add_event(EVT_BYTE, CH_STOP);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: set_regs(20'd300000, 20'd50000, 20'd100, 20'd80, 20'd500000, 20'd5, 20'd1);
				2: set_regs(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
					20'($urandom), 20'($urandom), 20'($urandom));
				3: set_regs(20'($urandom_range(0, 1000000)), 20'($urandom_range(0, 200000)),
					20'($urandom_range(0, 500)), 20'($urandom_range(20, 200)),
					20'($urandom_range(0, 3000)), 20'd255, 20'd255);
				default: set_regs(20'($urandom_range(0, 1000000)),
					20'($urandom_range(0, 200000)), 20'($urandom_range(0, 2000)),
					20'($urandom_range(1, 400)), 20'($urandom_range(0, 1000000)),
					20'($urandom_range(0, 255)), 20'($urandom_range(0, 255)));
			endcase
			case (p)
				1: begin
					idle_max = 0;
					stall_max = 0;
					holds_asked++;
				end
				2: begin
					idle_max = IDLE_MAX;
					stall_max = 0;
				end
				3: begin
					idle_max = 0;
					stall_max = IDLE_MAX;
				end
				4: begin
					idle_max = $urandom_range(0, IDLE_MAX);
					stall_max = $urandom_range(0, IDLE_MAX);
				end
				default: begin
					idle_max = IDLE_MAX;
					stall_max = IDLE_MAX;
				end
			endcase
			add_random(RANDOM_PER_PHASE);
			settle();
		end

		$display("%0d events applied, %0d status words checked, %0d register writes",
			events_applied, words_checked, reg_writes);
		$display("%0d register settings incl. extremes, edge bursts and a long status hold",
			settings_used);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/mspc_pkg.sv
rtl/mspc_in_if.sv
rtl/mspc_out_if.sv
rtl/mspc_cfg_if.sv
rtl/mspc_pi_pipe.sv
rtl/mspc_result_buf.sv
rtl/motor_speed_pi_controller_core.sv
tb/motor_speed_pi_controller_core_test.sv
